// File: rtl/tff_pkg.sv
// ----------------------------------------------------------------------------
// tff_pkg
// Shared types and constants of the telemetry frame formatter.
// ----------------------------------------------------------------------------
package tff_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CodeW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TwoW = 7;     // 0..99 fields
  localparam int unsigned TempW = 10;   // 0..999 tenths
  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW = 6;     // byte position in a frame, up to 36

  localparam logic [TwoW-1:0]  SatTwo  = 7'd99;
  localparam logic [TempW-1:0] SatTemp = 10'd999;

  localparam logic [7:0] ByteStart = 8'h01;
  localparam logic [7:0] ByteEnd   = 8'hFE;
  localparam logic [7:0] Digit0    = 8'h30;

  localparam logic [PosW-1:0] LenTime   = 6'h0C;
  localparam logic [PosW-1:0] LenRef    = 6'h08;
  localparam logic [PosW-1:0] LenReport = 6'h25;
  localparam logic [PosW-1:0] LenClear  = 6'h04;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CODE_TIME   = 3'd0,
    REG_CODE_REF    = 3'd1,
    REG_CODE_REPORT = 3'd2,
    REG_CODE_CLEAR  = 3'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FRM_TIME   = 2'd0,
    FRM_REF    = 2'd1,
    FRM_REPORT = 2'd2,
    FRM_CLEAR  = 2'd3
  } frame_e;

  // one classified message, temperatures already split into whole degrees and tenths digit
  typedef struct packed {
    frame_e              frame;
    logic [CodeW-1:0]    command;
    logic [TwoW-1:0]     hours;
    logic [TwoW-1:0]     minutes;
    logic [TwoW-1:0]     seconds;
    logic [TwoW-1:0]     meas_whole;
    logic [DigitW-1:0]   meas_frac;
    logic [TwoW-1:0]     ref_whole;
    logic [DigitW-1:0]   ref_frac;
    logic [TwoW-1:0]     duty;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

  function automatic logic [PosW-1:0] frame_len(frame_e f);
    logic [PosW-1:0] len;
    case (f)
      FRM_TIME:   len = LenTime;
      FRM_REF:    len = LenRef;
      FRM_REPORT: len = LenReport;
      FRM_CLEAR:  len = LenClear;
      default:    len = LenClear;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/tff_front.sv
// ----------------------------------------------------------------------------
// tff_front
// Holds the command codes, takes messages, classifies and clamps them and
// splits the temperatures into whole degrees and tenths for the queue.
// ----------------------------------------------------------------------------
module tff_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tff_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [tff_pkg::CodeW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tff_pkg::CodeW-1:0]           command_i,
  input  logic [tff_pkg::TwoW-1:0]            hours_i,
  input  logic [tff_pkg::TwoW-1:0]            minutes_i,
  input  logic [tff_pkg::TwoW-1:0]            seconds_i,
  input  logic [tff_pkg::TempW-1:0]           measured_tenths_i,
  input  logic [tff_pkg::TempW-1:0]           reference_tenths_i,
  input  logic [tff_pkg::TwoW-1:0]            duty_percent_i,
  input  logic                                q_full_i,
  output tff_pkg::q_wr_t                      q_wr_o
);

  typedef struct packed {
    tff_pkg::frame_e                frame;
    logic [tff_pkg::CodeW-1:0]      command;
    logic [tff_pkg::TwoW-1:0]       hours;
    logic [tff_pkg::TwoW-1:0]       minutes;
    logic [tff_pkg::TwoW-1:0]       seconds;
    logic [tff_pkg::TempW-1:0]      meas;
    logic [tff_pkg::TempW-1:0]      refr;
    logic [tff_pkg::TwoW-1:0]       duty;
  } item_t;

  logic [tff_pkg::CodeW-1:0] code_time_q, code_ref_q, code_report_q, code_clear_q;
  logic                      known;
  tff_pkg::frame_e           frame;
  item_t                     item_d, item_q;
  logic                      hold_d, hold_q;
  logic                      accept, push;
  logic [17:0]               meas_prod, ref_prod;
  logic [tff_pkg::TwoW-1:0]  meas_whole, ref_whole;
  logic [tff_pkg::TempW-1:0] meas_rem, ref_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_time_q   <= 8'd16;
      code_ref_q    <= 8'd32;
      code_report_q <= 8'd48;
      code_clear_q  <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tff_pkg::REG_CODE_TIME:   code_time_q   <= cfg_data_i;
        tff_pkg::REG_CODE_REF:    code_ref_q    <= cfg_data_i;
        tff_pkg::REG_CODE_REPORT: code_report_q <= cfg_data_i;
        tff_pkg::REG_CODE_CLEAR:  code_clear_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // first match wins: time, reference, report, clear
  always_comb begin
    known = 1'b1;
    frame = tff_pkg::FRM_CLEAR;
    if (command_i == code_time_q) begin
      frame = tff_pkg::FRM_TIME;
    end else if (command_i == code_ref_q) begin
      frame = tff_pkg::FRM_REF;
    end else if (command_i == code_report_q) begin
      frame = tff_pkg::FRM_REPORT;
    end else if (command_i == code_clear_q) begin
      frame = tff_pkg::FRM_CLEAR;
    end else begin
      known = 1'b0;
    end
  end

  always_comb begin
    item_d.frame   = frame;
    item_d.command = command_i;
    item_d.hours   = (hours_i   > tff_pkg::SatTwo) ? tff_pkg::SatTwo : hours_i;
    item_d.minutes = (minutes_i > tff_pkg::SatTwo) ? tff_pkg::SatTwo : minutes_i;
    item_d.seconds = (seconds_i > tff_pkg::SatTwo) ? tff_pkg::SatTwo : seconds_i;
    item_d.meas    = (measured_tenths_i > tff_pkg::SatTemp) ? tff_pkg::SatTemp
                                                            : measured_tenths_i;
    item_d.refr    = (reference_tenths_i > tff_pkg::SatTemp) ? tff_pkg::SatTemp
                                                             : reference_tenths_i;
    item_d.duty    = (duty_percent_i > tff_pkg::SatTwo) ? tff_pkg::SatTwo : duty_percent_i;
  end

  assign in_stall_o = hold_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = hold_q && !q_full_i;

  // unknown commands are taken and dropped here
  always_comb begin
    hold_d = hold_q;
    if (push) begin
      hold_d = 1'b0;
    end
    if (accept && known) begin
      hold_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && known) begin
      item_q <= item_d;
    end
  end

  // t/10 as (t*205)>>11, exact for t below 1029
  assign meas_prod  = 18'(item_q.meas) * 18'd205;
  assign ref_prod   = 18'(item_q.refr) * 18'd205;
  assign meas_whole = meas_prod[17:11];
  assign ref_whole  = ref_prod[17:11];
  assign meas_rem   = item_q.meas - ({3'b0, meas_whole} * 10'd10);
  assign ref_rem    = item_q.refr - ({3'b0, ref_whole} * 10'd10);

  always_comb begin
    q_wr_o.push             = push;
    q_wr_o.entry.frame      = item_q.frame;
    q_wr_o.entry.command    = item_q.command;
    q_wr_o.entry.hours      = item_q.hours;
    q_wr_o.entry.minutes    = item_q.minutes;
    q_wr_o.entry.seconds    = item_q.seconds;
    q_wr_o.entry.meas_whole = meas_whole;
    q_wr_o.entry.meas_frac  = meas_rem[tff_pkg::DigitW-1:0];
    q_wr_o.entry.ref_whole  = ref_whole;
    q_wr_o.entry.ref_frac   = ref_rem[tff_pkg::DigitW-1:0];
    q_wr_o.entry.duty       = item_q.duty;
  end

endmodule

// File: rtl/tff_queue.sv
// ----------------------------------------------------------------------------
// tff_queue
// Short FIFO of classified messages between the front and the byte emitter.
// ----------------------------------------------------------------------------
module tff_queue #(
  parameter int unsigned Depth = tff_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tff_pkg::q_wr_t q_wr_i,
  output logic           full_o,
  input  logic           pop_i,
  output tff_pkg::q_rd_t q_rd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tff_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign do_push = q_wr_i.push && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  assign q_rd_o.valid = (cnt_q != '0);
  assign q_rd_o.entry = mem_q[rd_ptr_q];

endmodule

// File: rtl/tff_back.sv
// ----------------------------------------------------------------------------
// tff_back
// Walks the head message byte by byte and drives the frame into the output
// register.
// ----------------------------------------------------------------------------
module tff_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tff_pkg::q_rd_t              q_rd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  frame_byte_o,
  output logic                        last_byte_o
);

  typedef enum logic [1:0] {
    SYM_CHAR = 2'd0,
    SYM_TENS = 2'd1,
    SYM_ONES = 2'd2,
    SYM_FRAC = 2'd3
  } sym_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChPct   = 8'h25;

  tff_pkg::entry_t                e;
  logic [tff_pkg::PosW-1:0]       pos_d, pos_q, len, pay_idx, rep_idx;
  logic                           load, at_last;
  logic                           out_valid_d, out_valid_q;
  logic [7:0]                     byte_d, byte_q;
  logic                           last_q;
  sym_e                           sym;
  logic [7:0]                     ch;
  logic [tff_pkg::TwoW-1:0]       dval;
  logic [tff_pkg::DigitW-1:0]     frac;
  logic [13:0]                    tens_prod;
  logic [tff_pkg::DigitW-1:0]     tens;
  logic [tff_pkg::TwoW-1:0]       ones;
  logic [7:0]                     pay_byte;

  assign e       = q_rd_i.entry;
  assign len     = tff_pkg::frame_len(e.frame);
  assign at_last = (pos_q == len - 1'b1);
  assign load    = q_rd_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && at_last;

  // payload index mapped onto the report layout; reference reuses its Tr field
  assign pay_idx = pos_q - 6'd3;
  assign rep_idx = (e.frame == tff_pkg::FRM_REF) ? pay_idx + 6'd22 : pay_idx;

  always_comb begin
    sym  = SYM_CHAR;
    ch   = ChColon;
    dval = e.hours;
    frac = e.meas_frac;
    case (rep_idx)
      6'd0:  begin sym = SYM_TENS; dval = e.hours;      end
      6'd1:  begin sym = SYM_ONES; dval = e.hours;      end
      6'd2:  ch = ChColon;
      6'd3:  begin sym = SYM_TENS; dval = e.minutes;    end
      6'd4:  begin sym = SYM_ONES; dval = e.minutes;    end
      6'd5:  ch = ChColon;
      6'd6:  begin sym = SYM_TENS; dval = e.seconds;    end
      6'd7:  begin sym = SYM_ONES; dval = e.seconds;    end
      6'd8:  ch = ChDash;
      6'd9:  ch = ChDash;
      6'd10: ch = ChT;
      6'd11: ch = ChM;
      6'd12: ch = ChColon;
      6'd13: begin sym = SYM_TENS; dval = e.meas_whole; end
      6'd14: begin sym = SYM_ONES; dval = e.meas_whole; end
      6'd15: ch = ChDot;
      6'd16: begin sym = SYM_FRAC; frac = e.meas_frac;  end
      6'd17: ch = ChDash;
      6'd18: ch = ChDash;
      6'd19: ch = ChT;
      6'd20: ch = ChR;
      6'd21: ch = ChColon;
      6'd22: begin sym = SYM_TENS; dval = e.ref_whole;  end
      6'd23: begin sym = SYM_ONES; dval = e.ref_whole;  end
      6'd24: ch = ChDot;
      6'd25: begin sym = SYM_FRAC; frac = e.ref_frac;   end
      6'd26: ch = ChDash;
      6'd27: ch = ChDash;
      6'd28: ch = ChD;
      6'd29: ch = ChColon;
      6'd30: begin sym = SYM_TENS; dval = e.duty;       end
      6'd31: begin sym = SYM_ONES; dval = e.duty;       end
      6'd32: ch = ChPct;
      default: ch = ChColon;
    endcase
  end

  // v/10 as (v*103)>>10, exact for v up to 99
  assign tens_prod = 14'(dval) * 14'd103;
  assign tens      = tens_prod[13:10];
  assign ones      = dval - (7'(tens) * 7'd10);

  always_comb begin
    case (sym)
      SYM_TENS: pay_byte = tff_pkg::Digit0 + 8'(tens);
      SYM_ONES: pay_byte = tff_pkg::Digit0 + 8'(ones[tff_pkg::DigitW-1:0]);
      SYM_FRAC: pay_byte = tff_pkg::Digit0 + 8'(frac);
      SYM_CHAR: pay_byte = ch;
      default:  pay_byte = ch;
    endcase
  end

  always_comb begin
    if (pos_q == 6'd0) begin
      byte_d = tff_pkg::ByteStart;
    end else if (pos_q == 6'd1) begin
      byte_d = e.command;
    end else if (pos_q == 6'd2) begin
      byte_d = 8'(len);
    end else if (at_last) begin
      byte_d = tff_pkg::ByteEnd;
    end else begin
      byte_d = pay_byte;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = at_last ? '0 : pos_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= at_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule

// File: rtl/telemetry_frame_formatter.sv
// ----------------------------------------------------------------------------
// telemetry_frame_formatter
// Turns one telemetry message into an ASCII frame sent one byte per beat.
//
//   channel  handshake              payload
//   cfg      cfg_we_i               cfg_idx_i, cfg_data_i
//   in       in_valid_i/in_stall_o  command, hours, minutes, seconds, temps, duty
//   out      out_valid_o/out_stall_i frame_byte, last_byte
//
// A frame has 4, 8, 12 or 37 bytes, and the byte emitter gives one byte per
// cycle while out_stall_i is low; messages run back to back. The first byte
// passes the front register, the queue and the output register. Unknown
// commands are absorbed by the front. Reset restores the default command codes
// and empties the pipeline. The output register holds under out_stall_i; the
// front keeps taking messages until the queue and its own holding register
// are both full.
// ----------------------------------------------------------------------------
module telemetry_frame_formatter #(
  parameter int unsigned QueueDepth = tff_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tff_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tff_pkg::CodeW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tff_pkg::CodeW-1:0]     command_i,
  input  logic [tff_pkg::TwoW-1:0]      hours_i,
  input  logic [tff_pkg::TwoW-1:0]      minutes_i,
  input  logic [tff_pkg::TwoW-1:0]      seconds_i,
  input  logic [tff_pkg::TempW-1:0]     measured_tenths_i,
  input  logic [tff_pkg::TempW-1:0]     reference_tenths_i,
  input  logic [tff_pkg::TwoW-1:0]      duty_percent_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    frame_byte_o,
  output logic                          last_byte_o
);

  tff_pkg::q_wr_t q_wr;
  tff_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  tff_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .hours_i            (hours_i),
    .minutes_i          (minutes_i),
    .seconds_i          (seconds_i),
    .measured_tenths_i  (measured_tenths_i),
    .reference_tenths_i (reference_tenths_i),
    .duty_percent_i     (duty_percent_i),
    .q_full_i           (q_full),
    .q_wr_o             (q_wr)
  );

  tff_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  tff_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_rd_i       (q_rd),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> frame_byte_o == tff_pkg::ByteEnd)
    else $error("last byte flag on a byte other than the end byte");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> !q_full)
    else $error("front pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_rd.valid)
    else $error("back popped an empty queue");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled while the queue has room");

endmodule

// File: tb/sv/tff_frame_checker.sv
// ----------------------------------------------------------------------------
// tff_frame_checker
// Watches the config port and both channels of the telemetry frame formatter,
// builds the expected ASCII frame for every accepted message and compares the
// outgoing beats, in order, with those frames.
// ----------------------------------------------------------------------------
module tff_frame_checker
  import tff_pkg::*;
#(
  parameter logic [CodeW-1:0] CodeTimeRst   = '0,
  parameter logic [CodeW-1:0] CodeRefRst    = '0,
  parameter logic [CodeW-1:0] CodeReportRst = '0,
  parameter logic [CodeW-1:0] CodeClearRst  = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CodeW-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CodeW-1:0]     command_i,
  input  logic [TwoW-1:0]      hours_i,
  input  logic [TwoW-1:0]      minutes_i,
  input  logic [TwoW-1:0]      seconds_i,
  input  logic [TempW-1:0]     measured_tenths_i,
  input  logic [TempW-1:0]     reference_tenths_i,
  input  logic [TwoW-1:0]      duty_percent_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           frame_byte_i,
  input  logic                 last_byte_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportChars = 33;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic [CodeW-1:0] code_time;
  logic [CodeW-1:0] code_ref;
  logic [CodeW-1:0] code_report;
  logic [CodeW-1:0] code_clear;
  frame_beat_t      frame_q [$];
  frame_beat_t      exp_beat;

  // two ASCII digits, clamped at 99
  function automatic logic [15:0] two_digits(logic [TwoW-1:0] v);
    int unsigned n;
    n = (v > SatTwo) ? SatTwo : v;
    return {Digit0 + 8'(n / 10), Digit0 + 8'(n % 10)};
  endfunction

  // TT.T, clamped at 99.9
  function automatic logic [31:0] temp_text(logic [TempW-1:0] v);
    int unsigned n;
    n = (v > SatTemp) ? SatTemp : v;
    return {two_digits(TwoW'(n / 10)), ".", Digit0 + 8'(n % 10)};
  endfunction

  function automatic void expect_beat(logic [7:0] data, logic last);
    frame_q.push_back('{data, last});
  endfunction

  function automatic void predict_frame(logic [CodeW-1:0] cmd, logic [TwoW-1:0] hh,
                                        logic [TwoW-1:0] mm, logic [TwoW-1:0] ss,
                                        logic [TempW-1:0] meas, logic [TempW-1:0] refr,
                                        logic [TwoW-1:0] duty);
    frame_e                     kind;
    logic [8*ReportChars-1:0]   text;
    logic [63:0]                clock_text;
    logic [7:0]                 len_byte;
    int                         chars;
    // first matching code wins when codes collide
    if (cmd == code_time) kind = FRM_TIME;
    else if (cmd == code_ref) kind = FRM_REF;
    else if (cmd == code_report) kind = FRM_REPORT;
    else if (cmd == code_clear) kind = FRM_CLEAR;
    else return;
    clock_text = {two_digits(hh), ":", two_digits(mm), ":", two_digits(ss)};
    text = '0;
    case (kind)
      FRM_TIME: begin
        len_byte = 8'(LenTime);
        text = clock_text;
        chars = 8;
      end
      FRM_REF: begin
        len_byte = 8'(LenRef);
        text = temp_text(refr);
        chars = 4;
      end
      FRM_REPORT: begin
        len_byte = 8'(LenReport);
        text = {clock_text, "--Tm:", temp_text(meas), "--Tr:", temp_text(refr),
                "--D:", two_digits(duty), "%"};
        chars = ReportChars;
      end
      default: begin
        len_byte = 8'(LenClear);
        chars = 0;
      end
    endcase
    expect_beat(ByteStart, 1'b0);
    expect_beat(cmd, 1'b0);
    expect_beat(len_byte, 1'b0);
    for (int i = chars - 1; i >= 0; i--) expect_beat(text[i*8 +: 8], 1'b0);
    expect_beat(ByteEnd, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_time    = CodeTimeRst;
      code_ref     = CodeRefRst;
      code_report  = CodeReportRst;
      code_clear   = CodeClearRst;
      frame_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      beats_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CODE_TIME:   code_time   = cfg_data_i;
          REG_CODE_REF:    code_ref    = cfg_data_i;
          REG_CODE_REPORT: code_report = cfg_data_i;
          REG_CODE_CLEAR:  code_clear  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_frame(command_i, hours_i, minutes_i, seconds_i, measured_tenths_i,
                      reference_tenths_i, duty_percent_i);
      end
      if (out_valid_i && !out_stall_i) begin
        beats_o++;
        if (frame_q.size() == 0) begin
          $error("unexpected beat: frame_byte=%02h last_byte=%b", frame_byte_i, last_byte_i);
          fail_count_o++;
        end else begin
          exp_beat = frame_q.pop_front();
          if (frame_byte_i !== exp_beat.data) begin
            $error("frame_byte: expected %02h, got %02h", exp_beat.data, frame_byte_i);
            fail_count_o++;
          end
          if (last_byte_i !== exp_beat.last) begin
            $error("last_byte: expected %b, got %b", exp_beat.last, last_byte_i);
            fail_count_o++;
          end
        end
      end
      pending_o = frame_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the telemetry frame formatter: drives messages and command-code
// writes with random gaps and back-pressure, leaves the checking of every
// frame byte to tff_frame_checker, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tff_pkg::*;

  localparam logic [CodeW-1:0] CodeTimeRst   = 8'd16;
  localparam logic [CodeW-1:0] CodeRefRst    = 8'd32;
  localparam logic [CodeW-1:0] CodeReportRst = 8'd48;
  localparam logic [CodeW-1:0] CodeClearRst  = 8'd64;
  localparam logic [CodeW-1:0] CodeShared    = 8'hAA;
  localparam logic [CodeW-1:0] CodeOther     = 8'h55;

  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned FramedPerPhase = 32;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned TimeoutNs      = 3_000_000;

  typedef struct packed {
    logic [CodeW-1:0] command;
    logic [TwoW-1:0]  hours;
    logic [TwoW-1:0]  minutes;
    logic [TwoW-1:0]  seconds;
    logic [TempW-1:0] meas_tenths;
    logic [TempW-1:0] ref_tenths;
    logic [TwoW-1:0]  duty;
  } msg_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CodeW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CodeW-1:0]   command_i = '0;
  logic [TwoW-1:0]    hours_i = '0;
  logic [TwoW-1:0]    minutes_i = '0;
  logic [TwoW-1:0]    seconds_i = '0;
  logic [TempW-1:0]   measured_tenths_i = '0;
  logic [TempW-1:0]   reference_tenths_i = '0;
  logic [TwoW-1:0]    duty_percent_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         frame_byte_o;
  logic               last_byte_o;

  logic               steady = 1'b0;  // no gaps and no stalls while set
  logic [CodeW-1:0]   codes [4];
  int unsigned        msgs_sent;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        beats;

  telemetry_frame_formatter u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .hours_i            (hours_i),
    .minutes_i          (minutes_i),
    .seconds_i          (seconds_i),
    .measured_tenths_i  (measured_tenths_i),
    .reference_tenths_i (reference_tenths_i),
    .duty_percent_i     (duty_percent_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_byte_o       (frame_byte_o),
    .last_byte_o        (last_byte_o)
  );

  tff_frame_checker #(
    .CodeTimeRst   (CodeTimeRst),
    .CodeRefRst    (CodeRefRst),
    .CodeReportRst (CodeReportRst),
    .CodeClearRst  (CodeClearRst)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .hours_i            (hours_i),
    .minutes_i          (minutes_i),
    .seconds_i          (seconds_i),
    .measured_tenths_i  (measured_tenths_i),
    .reference_tenths_i (reference_tenths_i),
    .duty_percent_i     (duty_percent_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_byte_i       (frame_byte_o),
    .last_byte_i        (last_byte_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .beats_o            (beats)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 35);
  end

  function automatic msg_t make_msg(logic [CodeW-1:0] cmd, int unsigned hh, int unsigned mm,
                                    int unsigned ss, int unsigned tm, int unsigned tr,
                                    int unsigned duty);
    msg_t m;
    m.command     = cmd;
    m.hours       = TwoW'(hh);
    m.minutes     = TwoW'(mm);
    m.seconds     = TwoW'(ss);
    m.meas_tenths = TempW'(tm);
    m.ref_tenths  = TempW'(tr);
    m.duty        = TwoW'(duty);
    return m;
  endfunction

  // mostly in range, one field in ten anywhere in its width to hit the clamps
  function automatic msg_t random_msg(logic [CodeW-1:0] cmd);
    msg_t m;
    m.command     = cmd;
    m.hours       = ($urandom_range(0, 9) == 0) ? TwoW'($urandom) : TwoW'($urandom_range(0, 99));
    m.minutes     = ($urandom_range(0, 9) == 0) ? TwoW'($urandom) : TwoW'($urandom_range(0, 99));
    m.seconds     = ($urandom_range(0, 9) == 0) ? TwoW'($urandom) : TwoW'($urandom_range(0, 99));
    m.meas_tenths = ($urandom_range(0, 9) == 0) ? TempW'($urandom)
                                                : TempW'($urandom_range(0, 999));
    m.ref_tenths  = ($urandom_range(0, 9) == 0) ? TempW'($urandom)
                                                : TempW'($urandom_range(0, 999));
    m.duty        = ($urandom_range(0, 9) == 0) ? TwoW'($urandom) : TwoW'($urandom_range(0, 99));
    return m;
  endfunction

  // starts at a falling edge, returns at the rising edge that took the beat
  task automatic send_msg(input msg_t m);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= m.command;
    hours_i            <= m.hours;
    minutes_i          <= m.minutes;
    seconds_i          <= m.seconds;
    measured_tenths_i  <= m.meas_tenths;
    reference_tenths_i <= m.ref_tenths;
    duty_percent_i     <= m.duty;
    do @(posedge clk_i); while (in_stall_o);
    msgs_sent++;
  endtask

  // unknown commands leave nothing to wait for, hence the extra cycles
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CodeW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx <= REG_CODE_CLEAR) codes[idx] = val;
  endtask

  initial begin
    logic [CodeW-1:0] pick [4];
    logic [CodeW-1:0] cmd;
    int unsigned      framed;
    msgs_sent = 0;
    codes = '{CodeTimeRst, CodeRefRst, CodeReportRst, CodeClearRst};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default codes: every layout at the ends of its fields, then unknowns
    send_msg(make_msg(CodeTimeRst, 0, 0, 0, 0, 0, 0));
    send_msg(make_msg(CodeTimeRst, 99, 99, 99, 999, 999, 99));
    send_msg(make_msg(CodeTimeRst, 127, 100, 127, 0, 0, 0));
    send_msg(make_msg(CodeRefRst, 0, 0, 0, 0, 0, 0));
    send_msg(make_msg(CodeRefRst, 0, 0, 0, 0, 999, 0));
    send_msg(make_msg(CodeRefRst, 127, 127, 127, 1023, 1023, 127));
    send_msg(make_msg(CodeReportRst, 0, 0, 0, 0, 0, 0));
    send_msg(make_msg(CodeReportRst, 99, 99, 99, 999, 999, 99));
    send_msg(make_msg(CodeReportRst, 127, 127, 127, 1023, 1023, 127));
    send_msg(make_msg(CodeReportRst, 12, 34, 56, 215, 207, 45));
    send_msg(make_msg(CodeClearRst, 127, 127, 127, 1023, 1023, 127));
    send_msg(make_msg('0, 1, 2, 3, 4, 5, 6));
    send_msg(make_msg('1, 1, 2, 3, 4, 5, 6));
    send_msg(make_msg(CodeTimeRst + 8'd1, 1, 2, 3, 4, 5, 6));

    // all codes equal: priority time, reference, report, clear
    wait_idle();
    for (int r = REG_CODE_TIME; r <= REG_CODE_CLEAR; r++) write_reg(CfgIdxW'(r), CodeShared);
    for (int r = REG_CODE_CLEAR + 1; r < 2 ** CfgIdxW; r++) write_reg(CfgIdxW'(r), '0);
    send_msg(make_msg(CodeShared, 23, 59, 59, 0, 0, 0));
    send_msg(make_msg('0, 1, 1, 1, 1, 1, 1));
    send_msg(make_msg(CodeTimeRst, 1, 1, 1, 1, 1, 1));
    wait_idle();
    write_reg(REG_CODE_TIME, '0);
    send_msg(make_msg(CodeShared, 0, 0, 0, 555, 321, 0));
    send_msg(make_msg('0, 7, 8, 9, 0, 0, 0));
    wait_idle();
    write_reg(REG_CODE_REF, '1);
    send_msg(make_msg(CodeShared, 8, 5, 30, 123, 456, 78));
    send_msg(make_msg('1, 0, 0, 0, 0, 100, 0));
    wait_idle();
    write_reg(REG_CODE_REPORT, CodeOther);
    send_msg(make_msg(CodeShared, 1, 2, 3, 4, 5, 6));

    for (int p = 0; p < RandomPhases; p++) begin
      wait_idle();
      case (p)
        0: pick = '{CodeTimeRst, CodeRefRst, CodeReportRst, CodeClearRst};
        1: pick = '{'1, '0, 8'h80, 8'h7F};
        4: begin
          foreach (pick[r]) pick[r] = $urandom_range(0, 1) ? CodeShared : CodeOther;
        end
        5: pick = '{'0, '1, 8'h01, 8'hFE};
        default: begin
          foreach (pick[r]) pick[r] = CodeW'($urandom);
        end
      endcase
      for (int r = REG_CODE_TIME; r <= REG_CODE_CLEAR; r++) write_reg(CfgIdxW'(r), pick[r]);
      write_reg(CfgIdxW'($urandom_range(REG_CODE_CLEAR + 1, 2 ** CfgIdxW - 1)),
                CodeW'($urandom));
      steady = (p == 3);
      framed = 0;
      while (framed < FramedPerPhase) begin
        if ($urandom_range(0, 99) < 82) cmd = codes[$urandom_range(0, 3)];
        else cmd = CodeW'($urandom);
        if (cmd == codes[0] || cmd == codes[1] || cmd == codes[2] || cmd == codes[3]) framed++;
        send_msg(random_msg(cmd));
      end
    end
    steady = 1'b0;
    wait_idle();

    $display("Covered %0d messages under %0d command-code settings, checked %0d frame bytes.",
             msgs_sent, RandomPhases + 5, beats);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d frame bytes outstanding.", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
